>>> hdl/rcic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcic_pkg: shared types and functions for the region CRC-32C checker
// Holds the verdict codes and the byte-parallel CRC-32C update.
// ----------------------------------------------------------------------------
package rcic_pkg;

    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
    localparam logic [3:0]  MAX_BYTES   = 4'd8;
    localparam int unsigned REGION_W    = 6;
    localparam int unsigned CRC_W       = 32;
    localparam int unsigned DATA_W      = 64;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned VERDICT_W   = 2;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_LEARNED  = 2'd0,
        VERDICT_MATCH    = 2'd1,
        VERDICT_TAMPERED = 2'd2,
        VERDICT_SKIPPED  = 2'd3
    } t_verdict;

    // Reflected CRC-32C over one byte, bit by bit.
    function automatic logic [CRC_W-1:0] crc32c_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Fold up to eight low-order bytes of data into crc, lowest byte first.
    function automatic logic [CRC_W-1:0] crc32c_update(input logic [CRC_W-1:0] crc,
                                                       input logic [DATA_W-1:0] data,
                                                       input logic [COUNT_W-1:0] count);
        logic [CRC_W-1:0]   c;
        logic [COUNT_W-1:0] n;
        c = crc;
        n = (count > MAX_BYTES) ? MAX_BYTES : count;
        for (int i = 0; i < 8; i++) begin
            if (COUNT_W'(i) < n) begin
                c = crc32c_byte(c, data[8*i +: 8]);
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/rcic_crc_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcic_crc_unit: running CRC accumulator
// Folds each accepted item into the running CRC; a last item restarts it.
// ----------------------------------------------------------------------------
module rcic_crc_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [rcic_pkg::DATA_W-1:0]   i_data,
    input  logic [rcic_pkg::COUNT_W-1:0]  i_byte_count,
    input  logic                          i_last,
    output logic [rcic_pkg::CRC_W-1:0]    o_crc_next
);
    import rcic_pkg::*;

    logic [CRC_W-1:0] r_running_crc;
    logic [CRC_W-1:0] n_running_crc;

    assign o_crc_next = crc32c_update(r_running_crc, i_data, i_byte_count);

    always_comb begin
        n_running_crc = r_running_crc;
        if (i_accept) begin
            n_running_crc = i_last ? '0 : o_crc_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_crc <= '0;
        end else begin
            r_running_crc <= n_running_crc;
        end
    end

endmodule

>>> hdl/rcic_ref_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcic_ref_table: reference CRC memory and learned marks
// One write port and one registered read port; learned marks live in flops.
// ----------------------------------------------------------------------------
module rcic_ref_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [rcic_pkg::CRC_W-1:0]    o_rd_ref,
    input  logic [AW-1:0]                 i_chk_addr,
    output logic                          o_chk_learned,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [rcic_pkg::CRC_W-1:0]    i_wr_data
);
    import rcic_pkg::*;

    logic [CRC_W-1:0] r_mem [DEPTH];
    logic [CRC_W-1:0] r_rd_ref;
    logic [DEPTH-1:0] r_learned;

    assign o_rd_ref      = r_rd_ref;
    assign o_chk_learned = r_learned[i_chk_addr];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // Forward a same-cycle write to the same entry.
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_ref <= i_wr_data;
            end else begin
                r_rd_ref <= r_mem[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learned <= '0;
        end else if (i_wr_en) begin
            r_learned[i_wr_addr] <= 1'b1;
        end
    end

endmodule

>>> hdl/region_crc32c_integrity_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_crc32c_integrity_check: per-region CRC-32C learn and verify
// Streams region bytes through CRC-32C and checks each run against a stored
// reference.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries up to eight bytes per
//   item, lowest byte first. Items are folded into one running CRC; an item
//   with i_last set closes the run and yields one result item on the output
//   channel (o_out_valid / i_out_ready).
//   A result passes through the compare stage, where the reference memory
//   read is registered, and then through the output register.
//   Throughput: one item per cycle while o_in_ready is high; the CRC update
//   over eight bytes is combinational, and a write to the same entry in the
//   same cycle as a reference read is forwarded to the read.
//   The first run of a region below REGION_COUNT stores its CRC as the reference;
//   later runs report match, tampered or skipped (zero CRC); others are skipped.
//   Reset clears the running CRC and all learned marks at once; there is no
//   clearing pass. When the receiver stalls, one more result is held in the
//   compare stage and input items keep flowing until that stage fills.
// ----------------------------------------------------------------------------
module region_crc32c_integrity_check #(
    parameter int REGION_COUNT = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [rcic_pkg::REGION_W-1:0]  i_region,
    input  logic [rcic_pkg::DATA_W-1:0]    i_data,
    input  logic [rcic_pkg::COUNT_W-1:0]   i_byte_count,
    input  logic                           i_last,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rcic_pkg::REGION_W-1:0]  o_result_region,
    output logic [rcic_pkg::CRC_W-1:0]     o_crc_value,
    output logic [rcic_pkg::VERDICT_W-1:0] o_verdict
);
    import rcic_pkg::*;

    // Only 64 regions are addressable, so the table never needs more entries.
    localparam int DEPTH = (REGION_COUNT < (1 << REGION_W)) ? REGION_COUNT
                                                            : (1 << REGION_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [10:0] REGION_LIMIT = 11'(REGION_COUNT);

    logic             in_accept;
    logic             p1_load;
    logic             p1_go;
    logic             in_range;
    logic [AW-1:0]    rd_addr;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] ref_crc;
    logic             learned;
    logic             wr_en;
    t_verdict         verdict;

    logic             r_p1_valid;
    logic [REGION_W-1:0] r_p1_region;
    logic [CRC_W-1:0] r_p1_crc;
    logic             r_p1_in_range;
    logic [AW-1:0]    r_p1_addr;

    logic             r_out_valid;
    logic [REGION_W-1:0] r_out_region;
    logic [CRC_W-1:0] r_out_crc;
    t_verdict         r_out_verdict;

    assign p1_go      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_p1_valid || p1_go;
    assign in_accept  = i_in_valid && o_in_ready;
    assign p1_load    = in_accept && i_last;

    assign in_range = (11'(i_region) < REGION_LIMIT);
    assign rd_addr  = in_range ? AW'(i_region) : '0;

    rcic_crc_unit u_crc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_data       (i_data),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_crc_next   (crc_next)
    );

    // Learn on the way out of the compare stage.
    assign wr_en = r_p1_valid && p1_go && r_p1_in_range && !learned;

    rcic_ref_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (p1_load),
        .i_rd_addr     (rd_addr),
        .o_rd_ref      (ref_crc),
        .i_chk_addr    (r_p1_addr),
        .o_chk_learned (learned),
        .i_wr_en       (wr_en),
        .i_wr_addr     (r_p1_addr),
        .i_wr_data     (r_p1_crc)
    );

    always_comb begin
        if (!r_p1_in_range) begin
            verdict = VERDICT_SKIPPED;
        end else if (!learned) begin
            verdict = VERDICT_LEARNED;
        end else if (r_p1_crc == '0) begin
            verdict = VERDICT_SKIPPED;
        end else if (r_p1_crc == ref_crc) begin
            verdict = VERDICT_MATCH;
        end else begin
            verdict = VERDICT_TAMPERED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p1_load) begin
            r_p1_region   <= i_region;
            r_p1_crc      <= crc_next;
            r_p1_in_range <= in_range;
            r_p1_addr     <= rd_addr;
        end
        if (r_p1_valid && p1_go) begin
            r_out_region  <= r_p1_region;
            r_out_crc     <= r_p1_crc;
            r_out_verdict <= verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (p1_load) begin
                r_p1_valid <= 1'b1;
            end else if (p1_go) begin
                r_p1_valid <= 1'b0;
            end
            if (p1_go) begin
                r_out_valid <= r_p1_valid;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_region = r_out_region;
    assign o_crc_value     = r_out_crc;
    assign o_verdict       = r_out_verdict;

endmodule

>>> hdl/rcic_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcic_checker: port-level checks for the region CRC-32C checker
// Watches the top level's ports and flags illegal result sequences.
// ----------------------------------------------------------------------------
module rcic_checker #(
    parameter int REGION_COUNT = 64
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           i_last,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [rcic_pkg::REGION_W-1:0]  o_result_region,
    input logic [rcic_pkg::CRC_W-1:0]     o_crc_value,
    input logic [rcic_pkg::VERDICT_W-1:0] o_verdict
);
    import rcic_pkg::*;

    localparam logic [10:0] REGION_LIMIT = 11'(REGION_COUNT);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result_region) && $stable(o_crc_value)
            && $stable(o_verdict))
        else $error("stalled result changed");

    // A fresh result always traces back to an accepted last item.
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && i_last, 2))
        else $error("result without a matching last item");

    // A zero CRC is never compared.
    a_zero_not_compared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_crc_value == '0) |->
            !((o_verdict == VERDICT_MATCH) || (o_verdict == VERDICT_TAMPERED)))
        else $error("zero CRC reported as compared");

    // Regions outside the table are always skipped.
    a_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (11'(o_result_region) >= REGION_LIMIT) |->
            (o_verdict == VERDICT_SKIPPED))
        else $error("out-of-range region not skipped");

    // Reset empties the output.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind region_crc32c_integrity_check rcic_checker #(
    .REGION_COUNT (REGION_COUNT)
) u_rcic_checker (.*);

>>> test/tb_region_crc32c_integrity_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_region_crc32c_integrity_check: testbench for the region CRC-32C checker
// Sends region byte runs through the input channel and checks every result
// item against a bit-serial CRC-32C predictor that also tracks the learned
// reference per region. The directed tests cover the lane and count extremes,
// empty items and every verdict. The random traffic mixes fresh runs, exact
// and tampered replays of learned runs, all-zero runs and noise. Sender gaps
// and receiver stalls vary throughout the run.
// ----------------------------------------------------------------------------
module tb_region_crc32c_integrity_check;
    import rcic_pkg::*;

    localparam int          REGIONS      = 64;
    localparam logic [31:0] CASTAGNOLI_R = 32'h82F6_3B78;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_ITEMS = 1950;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          MAX_REPORTS  = 10;

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [DATA_W-1:0]   data;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_item;

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [CRC_W-1:0]    crc;
        t_verdict            verdict;
    } t_region_result;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_LONG
    } t_stall_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [REGION_W-1:0]  i_region;
    logic [DATA_W-1:0]    i_data;
    logic [COUNT_W-1:0]   i_byte_count;
    logic                 i_last;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [REGION_W-1:0]  o_result_region;
    logic [CRC_W-1:0]     o_crc_value;
    logic [VERDICT_W-1:0] o_verdict;

    // predictor state
    logic [CRC_W-1:0]     run_crc;
    logic [CRC_W-1:0]     ref_crc_model [REGIONS];
    logic                 learned_model [REGIONS];
    t_region_result       expected_results [$];

    // stimulus state
    t_item                run_items [$];
    t_item                canon_run [REGIONS][$];
    int unsigned          burst_left;
    logic                 valid_up;
    logic                 no_idle;

    int unsigned          items_sent;
    int unsigned          runs_sent;
    int unsigned          fail_count;
    int unsigned          seen_verdicts [4];
    int unsigned          cycle_count = 0;

    region_crc32c_integrity_check #(
        .REGION_COUNT(REGIONS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_region        (i_region),
        .i_data          (i_data),
        .i_byte_count    (i_byte_count),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_region (o_result_region),
        .o_crc_value     (o_crc_value),
        .o_verdict       (o_verdict)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Reflected CRC-32C, one data bit at a time, lowest bit first.
    function automatic logic [CRC_W-1:0] crc32c_fold(input logic [CRC_W-1:0] seed,
                                                     input logic [DATA_W-1:0] bytes,
                                                     input int unsigned nbytes);
        logic [CRC_W-1:0] acc;
        logic             fb;
        acc = seed;
        for (int j = 0; j < 8 * nbytes; j++) begin
            fb  = acc[0] ^ bytes[j];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ CASTAGNOLI_R;
            end
        end
        return acc;
    endfunction

    function automatic int unsigned lanes_of(input logic [COUNT_W-1:0] count);
        return (count > 4'd8) ? 8 : int'(count);
    endfunction

    function automatic logic [COUNT_W-1:0] rand_count();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
            return 4'd8;
        end else if (roll < 9) begin
            return COUNT_W'($urandom_range(1, 7));
        end else begin
            return COUNT_W'($urandom_range(0, 15));
        end
    endfunction

    task automatic region_crc_accept(input t_item it);
        logic [CRC_W-1:0] crc;
        t_region_result   res;
        crc = crc32c_fold(run_crc, it.data, lanes_of(it.count));
        if (!it.last) begin
            run_crc = crc;
        end else begin
            run_crc    = '0;
            res.region = it.region;
            res.crc    = crc;
            if (!learned_model[it.region]) begin
                ref_crc_model[it.region] = crc;
                learned_model[it.region] = 1'b1;
                res.verdict = VERDICT_LEARNED;
            end else if (crc == '0) begin
                res.verdict = VERDICT_SKIPPED;
            end else if (crc == ref_crc_model[it.region]) begin
                res.verdict = VERDICT_MATCH;
            end else begin
                res.verdict = VERDICT_TAMPERED;
            end
            expected_results.push_back(res);
        end
    endtask

    task automatic send_item(input t_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = (no_idle || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                if (valid_up) begin
                    i_in_valid <= 1'b0;
                    valid_up = 1'b0;
                end
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        valid_up     = 1'b1;
        i_region     <= it.region;
        i_data       <= it.data;
        i_byte_count <= it.count;
        i_last       <= it.last;
        do @(posedge i_clk); while (!o_in_ready);
        region_crc_accept(it);
        items_sent++;
    endtask

    task automatic add_item(input logic [REGION_W-1:0] region, input logic [DATA_W-1:0] data,
                            input logic [COUNT_W-1:0] count, input logic last);
        t_item it;
        it.region = region;
        it.data   = data;
        it.count  = count;
        it.last   = last;
        run_items.push_back(it);
    endtask

    // Send the queued run; keep it for replay if it teaches a new reference.
    task automatic send_run();
        logic [REGION_W-1:0] tail_region;
        logic                fresh;
        tail_region = run_items[run_items.size() - 1].region;
        fresh       = !learned_model[tail_region];
        foreach (run_items[i]) begin
            send_item(run_items[i]);
        end
        if (fresh) begin
            canon_run[tail_region] = run_items;
        end
        run_items.delete();
        runs_sent++;
    endtask

    // Hold the sender until every expected result has come back.
    task automatic wait_for_results();
        if (valid_up) begin
            i_in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        do @(posedge i_clk); while (expected_results.size() != 0);
        burst_left = 0;
    endtask

    task automatic test_lane_extremes();
        add_item(6'd0, '1, 4'd1, 1'b1);
        send_run();
        add_item(6'd63, '1, 4'd8, 1'b1);
        send_run();
        add_item(6'd1, 64'h0123_4567_89AB_CDEF, 4'd8, 1'b1);
        send_run();
        // upper lanes carry junk that must be ignored
        add_item(6'd2, 64'hFFFF_FFFF_0000_0080, 4'd4, 1'b1);
        send_run();
        wait_for_results();
    endtask

    task automatic test_empty_items();
        add_item(6'd5, '1, 4'd0, 1'b1);
        send_run();
        add_item(6'd5, 64'h1234, 4'd0, 1'b1);
        send_run();
        add_item(6'd6, '1, 4'd0, 1'b0);
        add_item(6'd6, 64'h00C0_FFEE, 4'd3, 1'b1);
        send_run();
        wait_for_results();
    endtask

    task automatic test_count_saturation();
        add_item(6'd10, 64'h5A3C_96E1_0F7B_D248, 4'd15, 1'b1);
        send_run();
        add_item(6'd10, 64'h5A3C_96E1_0F7B_D248, 4'd8, 1'b1);
        send_run();
        add_item(6'd10, 64'h5A3C_96E1_0F7B_D248, 4'd9, 1'b1);
        send_run();
        add_item(6'd10, 64'h5A3C_96E1_0F7B_D248, 4'd12, 1'b1);
        send_run();
        wait_for_results();
    endtask

    task automatic test_run_verdicts();
        add_item(6'd20, 64'h8899_AABB_CCDD_EEFF, 4'd8, 1'b0);
        add_item(6'd20, 64'h0000_0077_6655_4433, 4'd5, 1'b1);
        send_run();
        add_item(6'd20, 64'h8899_AABB_CCDD_EEFF, 4'd8, 1'b0);
        add_item(6'd20, 64'h0000_0077_6655_4433, 4'd5, 1'b1);
        send_run();
        // one flipped bit: tampered, reference stays
        add_item(6'd20, 64'h8899_AABB_CCDD_EEFF, 4'd8, 1'b0);
        add_item(6'd20, 64'h0000_0077_6655_4432, 4'd5, 1'b1);
        send_run();
        add_item(6'd20, 64'h8899_AABB_CCDD_EEFF, 4'd8, 1'b0);
        add_item(6'd20, 64'h0000_0077_6655_4433, 4'd5, 1'b1);
        send_run();
        // zero bytes give a zero CRC on a learned region
        add_item(6'd20, '0, 4'd8, 1'b1);
        send_run();
        // region comes from the last item of the run
        add_item(6'd30, 64'h1357_9BDF_2468_ACE0, 4'd2, 1'b0);
        add_item(6'd31, 64'h0000_0000_0000_00E7, 4'd1, 1'b1);
        send_run();
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int unsigned  target, since_drain, kind, len, r, k, pick, nb, bitpos;
        t_item        it;
        target      = items_sent + RANDOM_ITEMS;
        since_drain = 0;
        while (items_sent < target) begin
            kind = $urandom_range(0, 99);
            r    = $urandom_range(0, REGIONS - 1);
            if (kind < 45 && canon_run[r].size() != 0) begin
                run_items = canon_run[r];
                pick = $urandom_range(0, 9);
                k    = $urandom_range(0, run_items.size() - 1);
                it   = run_items[k];
                nb   = lanes_of(it.count);
                if (pick < 2 && nb != 0) begin
                    bitpos = $urandom_range(0, 8 * nb - 1);
                    it.data[bitpos] = ~it.data[bitpos];
                end else if (pick < 3 && nb < 8) begin
                    // change only bytes beyond the count: still a match
                    bitpos = $urandom_range(8 * nb, DATA_W - 1);
                    it.data[bitpos] = ~it.data[bitpos];
                end
                run_items[k] = it;
            end else if (kind < 75) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    add_item(REGION_W'(r), {$urandom, $urandom}, rand_count(), i == len - 1);
                end
            end else if (kind < 85) begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) begin
                    add_item(REGION_W'(r), '0, COUNT_W'($urandom_range(0, 8)), i == len - 1);
                end
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    add_item(REGION_W'($urandom_range(0, REGIONS - 1)), {$urandom, $urandom},
                             COUNT_W'($urandom_range(0, 15)), i == len - 1);
                end
            end
            since_drain += run_items.size();
            send_run();
            if (since_drain > 400) begin
                wait_for_results();
                since_drain = 0;
                no_idle = ($urandom_range(0, 3) == 0);
            end
        end
        no_idle = 1'b0;
        wait_for_results();
    endtask

    task automatic check_result();
        t_region_result want;
        if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("ERROR: unexpected result region %0d crc %08h verdict %0d",
                         o_result_region, o_crc_value, o_verdict);
            end
        end else begin
            want = expected_results.pop_front();
            if (o_result_region !== want.region || o_crc_value !== want.crc ||
                o_verdict !== want.verdict) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("ERROR: region exp %0d got %0d, crc exp %08h got %08h, verdict exp %0d got %0d",
                             want.region, o_result_region, want.crc, o_crc_value,
                             want.verdict, o_verdict);
                end
            end else begin
                seen_verdicts[o_verdict]++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_result();
        end
    end

    initial begin : out_stall_pattern
        t_stall_mode mode;
        int unsigned mode_left;
        int unsigned hold;
        i_out_ready <= 1'b0;
        mode      = STALL_NONE;
        mode_left = 0;
        hold      = 0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 200);
            end else begin
                mode_left--;
            end
            case (mode)
                STALL_NONE: begin
                    i_out_ready <= 1'b1;
                end
                STALL_LIGHT: begin
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                end
                STALL_HEAVY: begin
                    i_out_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_out_ready <= (hold == 0);
                    hold = (hold == 0) ? $urandom_range(1, 20) : hold - 1;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ERROR: run exceeded %0d cycles, %0d results outstanding",
                     CYCLE_LIMIT, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int unsigned learned_regions;
        run_crc      = '0;
        burst_left   = 0;
        valid_up     = 1'b0;
        no_idle      = 1'b0;
        items_sent   = 0;
        runs_sent    = 0;
        fail_count   = 0;
        for (int i = 0; i < REGIONS; i++) begin
            ref_crc_model[i] = '0;
            learned_model[i] = 1'b0;
        end
        foreach (seen_verdicts[i]) begin
            seen_verdicts[i] = 0;
        end
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_region     <= '0;
        i_data       <= '0;
        i_byte_count <= '0;
        i_last       <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_lane_extremes();
        test_empty_items();
        test_count_saturation();
        test_run_verdicts();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            fail_count++;
            $display("ERROR: %0d results never arrived", expected_results.size());
        end
        learned_regions = 0;
        for (int i = 0; i < REGIONS; i++) begin
            learned_regions += learned_model[i];
        end
        $display("Sent %0d items in %0d runs; %0d of %0d regions learned.",
                 items_sent, runs_sent, learned_regions, REGIONS);
        $display("Results: %0d learned, %0d match, %0d tampered, %0d skipped; %0d errors.",
                 seen_verdicts[VERDICT_LEARNED], seen_verdicts[VERDICT_MATCH],
                 seen_verdicts[VERDICT_TAMPERED], seen_verdicts[VERDICT_SKIPPED], fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
